// ----- hdl/tnef_attribute_record_parser_top_defines.svh -----
// Assertion macros shared by the attribute record parser modules.
`ifndef TNEF_ATTRIBUTE_RECORD_PARSER_TOP_DEFINES_SVH
`define TNEF_ATTRIBUTE_RECORD_PARSER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define TARP_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tarp assertion failed");
// Next-cycle implication, checked outside reset.
`define TARP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tarp assertion failed");
`else
`define TARP_ASSERT(lbl, clk, rst_n, ante, cons)
`define TARP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/tarp_pkg.sv -----
// Types and constants of the attribute record parser.
`timescale 1ns / 1ps

package tarp_pkg;

    typedef enum logic [2:0] {
        PH_LEVEL   = 3'd0,
        PH_TYPNAM  = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CKSUM   = 3'd4
    } phase_t;

    localparam logic [7:0] LEVEL_MESSAGE    = 8'd1;
    localparam logic [7:0] LEVEL_ATTACHMENT = 8'd2;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  record_level;
        logic [15:0] attribute_type;
        logic [15:0] attribute_name;
        logic [31:0] payload_length;
        logic        checksum_good;
        logic        level_valid;
        logic        halted_flag;
    } res_t;

endpackage

// ----- hdl/tarp_parse.sv -----
// Record parse state machine: one stream byte per accepted item.
`timescale 1ns / 1ps
`include "tnef_attribute_record_parser_top_defines.svh"

module tarp_parse (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    stream_byte,
    input  logic          skip_bad_checksum,
    output logic          res_valid,
    output tarp_pkg::res_t res
);
    import tarp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  idx_reg, idx_next;
    logic [7:0]  level_reg, level_next;
    logic [31:0] tn_reg, tn_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] rem_reg, rem_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  ck_low_reg, ck_low_next;
    logic        stopped_reg, stopped_next;
    logic        ck_good;
    logic        live;

    assign live    = accept && !stopped_reg;
    assign ck_good = ({stream_byte, ck_low_reg} == sum_reg);

    // Next state
    always_comb
    begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        level_next   = level_reg;
        tn_next      = tn_reg;
        len_next     = len_reg;
        rem_next     = rem_reg;
        sum_next     = sum_reg;
        ck_low_next  = ck_low_reg;
        stopped_next = stopped_reg;
        if (live)
        begin
            case (phase_reg)
                PH_LEVEL:
                begin
                    level_next = stream_byte;
                    tn_next    = '0;
                    len_next   = '0;
                    sum_next   = '0;
                    idx_next   = '0;
                    phase_next = PH_TYPNAM;
                end
                PH_TYPNAM:
                begin
                    tn_next[{idx_reg, 3'b000} +: 8] = stream_byte;
                    if (idx_reg == 2'd3)
                    begin
                        idx_next   = '0;
                        phase_next = PH_LENGTH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
                PH_LENGTH:
                begin
                    len_next[{idx_reg, 3'b000} +: 8] = stream_byte;
                    if (idx_reg == 2'd3)
                    begin
                        idx_next   = '0;
                        rem_next   = len_next;
                        phase_next = (len_next == 32'd0) ? PH_CKSUM : PH_PAYLOAD;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    sum_next = sum_reg + {8'd0, stream_byte};
                    rem_next = rem_reg - 32'd1;
                    if (rem_reg == 32'd1)
                    begin
                        idx_next   = '0;
                        phase_next = PH_CKSUM;
                    end
                end
                PH_CKSUM:
                begin
                    if (idx_reg == 2'd0)
                    begin
                        ck_low_next = stream_byte;
                        idx_next    = 2'd1;
                    end
                    else
                    begin
                        // halt for good on a mismatch unless told to carry on
                        if (!ck_good && !skip_bad_checksum)
                            stopped_next = 1'b1;
                        idx_next   = '0;
                        phase_next = PH_LEVEL;
                    end
                end
                default:
                begin
                    idx_next   = '0;
                    phase_next = PH_LEVEL;
                end
            endcase
        end
    end

    // Outputs
    always_comb
    begin
        res_valid          = 1'b0;
        res.result_kind    = KIND_PAYLOAD;
        res.payload_byte   = '0;
        res.record_level   = level_reg;
        res.attribute_type = tn_reg[31:16];
        res.attribute_name = tn_reg[15:0];
        res.payload_length = len_reg;
        res.checksum_good  = 1'b0;
        res.level_valid    = level_reg inside {LEVEL_MESSAGE, LEVEL_ATTACHMENT};
        res.halted_flag    = 1'b0;
        if (live)
        begin
            case (phase_reg)
                PH_PAYLOAD:
                begin
                    res_valid        = 1'b1;
                    res.payload_byte = stream_byte;
                end
                PH_CKSUM:
                begin
                    if (idx_reg != 2'd0)
                    begin
                        res_valid         = 1'b1;
                        res.result_kind   = KIND_SUMMARY;
                        res.checksum_good = ck_good;
                        res.halted_flag   = !ck_good && !skip_bad_checksum;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LEVEL;
            idx_reg     <= '0;
            level_reg   <= '0;
            tn_reg      <= '0;
            len_reg     <= '0;
            rem_reg     <= '0;
            sum_reg     <= '0;
            ck_low_reg  <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            level_reg   <= level_next;
            tn_reg      <= tn_next;
            len_reg     <= len_next;
            rem_reg     <= rem_next;
            sum_reg     <= sum_next;
            ck_low_reg  <= ck_low_next;
            stopped_reg <= stopped_next;
        end
    end

    `TARP_ASSERT(a_stopped_silent, clk, rst_n, stopped_reg, !res_valid)
    `TARP_ASSERT_NEXT(a_stopped_sticks, clk, rst_n, stopped_reg, stopped_reg)
    `TARP_ASSERT_NEXT(a_halt_stops, clk, rst_n, res_valid && res.halted_flag, stopped_reg)

endmodule

// ----- hdl/tnef_attribute_record_parser_top.sv -----
// Attribute record parser top level: config register, parser and output skid stage.
`timescale 1ns / 1ps
`include "tnef_attribute_record_parser_top_defines.svh"

// Takes one stream byte per cycle while in_stall is low and gives zero or one
// result for each byte: every payload byte is passed through, and the second
// checksum byte of a record yields a summary with the header fields and
// checksum/level flags. A result is registered in the output register, or in
// the skid stage while the output register is stalled; the parser state machine
// finishes each byte as it is accepted. in_stall rises only while a second result
// waits in the skid stage behind a stalled output register; it then holds the
// input for the rest of the output stall and until the skid stage drains. After a checksum
// mismatch with skip_bad_checksum clear, the block keeps taking bytes but
// gives no further results until reset.
module tnef_attribute_record_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  stream_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  record_level,
    output logic [15:0] attribute_type,
    output logic [15:0] attribute_name,
    output logic [31:0] payload_length,
    output logic        checksum_good,
    output logic        level_valid,
    output logic        halted_flag
);
    import tarp_pkg::*;

    logic  skip_reg;
    logic  accept;
    logic  res_valid;
    res_t  res;
    logic  out_valid_reg, out_valid_next;
    res_t  out_data_reg, out_data_next;
    logic  skid_valid_reg, skid_valid_next;
    res_t  skid_data_reg, skid_data_next;
    logic  out_free;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skip_reg <= 1'b0;
        else if (cfg_wr_en)
            skip_reg <= cfg_wr_data;
    end

    tarp_parse u_parse (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .stream_byte       (stream_byte),
        .skip_bad_checksum (skip_reg),
        .res_valid         (res_valid),
        .res               (res)
    );

    assign out_free = !out_valid_reg || !out_stall;

    // Output register loads from skid first; park a new result in skid when blocked
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_data_next  = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = out_data_reg.result_kind;
    assign payload_byte   = out_data_reg.payload_byte;
    assign record_level   = out_data_reg.record_level;
    assign attribute_type = out_data_reg.attribute_type;
    assign attribute_name = out_data_reg.attribute_name;
    assign payload_length = out_data_reg.payload_length;
    assign checksum_good  = out_data_reg.checksum_good;
    assign level_valid    = out_data_reg.level_valid;
    assign halted_flag    = out_data_reg.halted_flag;

    `TARP_ASSERT(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `TARP_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_valid_reg && !out_stall, !skid_valid_reg)
    `TARP_ASSERT_NEXT(a_out_kept, clk, rst_n, out_valid_reg && out_stall, out_valid_reg)

endmodule

// ----- tb/sv/tnef_attribute_record_parser_top_tb.sv -----
// Testbench for the attribute record parser: byte stream stimulus, record prediction, checks.
`timescale 1ns / 1ps

module tnef_attribute_record_parser_top_tb;
    import tarp_pkg::*;

    typedef logic [7:0] byte_q_t [$];

    localparam int HALF_PERIOD = 5;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  stream_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  record_level;
    logic [15:0] attribute_type;
    logic [15:0] attribute_name;
    logic [31:0] payload_length;
    logic        checksum_good;
    logic        level_valid;
    logic        halted_flag;

    res_t seen_result;

    // stimulus and scoreboard
    byte_q_t pending_bytes;
    res_t    expected_results [$];
    int      send_idle_pct = 21;
    int      recv_idle_pct = 72;
    logic    long_hold = 1'b0;

    int error_count = 0;
    int bytes_queued = 0;
    int bytes_accepted = 0;
    int payloads_seen = 0;
    int summaries_seen = 0;
    int halts_seen = 0;
    int cfg_writes = 0;

    // predictor state
    bit          skip_cfg = 1'b0;
    phase_t      parse_ph = PH_LEVEL;
    logic [1:0]  fidx = '0;
    logic [7:0]  lvl_held = '0;
    logic [31:0] tn_word = '0;
    logic [31:0] len_word = '0;
    logic [31:0] remain = '0;
    logic [15:0] byte_sum = '0;
    logic [7:0]  ck_lo = '0;
    bit          halted = 1'b0;

    tnef_attribute_record_parser_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .stream_byte    (stream_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .payload_byte   (payload_byte),
        .record_level   (record_level),
        .attribute_type (attribute_type),
        .attribute_name (attribute_name),
        .payload_length (payload_length),
        .checksum_good  (checksum_good),
        .level_valid    (level_valid),
        .halted_flag    (halted_flag)
    );

    assign seen_result = {result_kind, payload_byte, record_level, attribute_type,
                          attribute_name, payload_length, checksum_good, level_valid,
                          halted_flag};

    always #HALF_PERIOD clk = ~clk;

    function automatic res_t record_header();
        res_t r;
        r = '0;
        r.record_level = lvl_held;
        r.attribute_type = tn_word[31:16];
        r.attribute_name = tn_word[15:0];
        r.payload_length = len_word;
        r.level_valid = (lvl_held == LEVEL_MESSAGE) || (lvl_held == LEVEL_ATTACHMENT);
        return r;
    endfunction

    // Advance the record parser by one byte and queue the result it gives.
    task automatic parse_byte(input logic [7:0] b);
        res_t        r;
        logic [15:0] ck;
        if (halted)
            return;
        case (parse_ph)
            PH_LEVEL:
            begin
                lvl_held = b;
                tn_word = '0;
                len_word = '0;
                byte_sum = '0;
                fidx = '0;
                parse_ph = PH_TYPNAM;
            end
            PH_TYPNAM:
            begin
                tn_word[fidx*8 +: 8] = b;
                if (fidx == 2'd3)
                    parse_ph = PH_LENGTH;
                fidx = fidx + 2'd1;
            end
            PH_LENGTH:
            begin
                len_word[fidx*8 +: 8] = b;
                if (fidx == 2'd3)
                begin
                    remain = len_word;
                    parse_ph = (len_word == 32'd0) ? PH_CKSUM : PH_PAYLOAD;
                end
                fidx = fidx + 2'd1;
            end
            PH_PAYLOAD:
            begin
                byte_sum = byte_sum + {8'd0, b};
                remain = remain - 32'd1;
                if (remain == 32'd0)
                begin
                    fidx = '0;
                    parse_ph = PH_CKSUM;
                end
                r = record_header();
                r.result_kind = KIND_PAYLOAD;
                r.payload_byte = b;
                expected_results.push_back(r);
            end
            PH_CKSUM:
            begin
                if (fidx == 2'd0)
                begin
                    ck_lo = b;
                    fidx = 2'd1;
                end
                else
                begin
                    ck = {b, ck_lo};
                    r = record_header();
                    r.result_kind = KIND_SUMMARY;
                    r.checksum_good = (ck == byte_sum);
                    if (!r.checksum_good && !skip_cfg)
                    begin
                        halted = 1'b1;
                        r.halted_flag = 1'b1;
                    end
                    fidx = '0;
                    parse_ph = PH_LEVEL;
                    expected_results.push_back(r);
                end
            end
            default:
            begin
                parse_ph = PH_LEVEL;
                fidx = '0;
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic check_result();
        res_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("unexpected result", 32'(seen_result.result_kind), 32'd0);
            return;
        end
        want = expected_results.pop_front();
        if (seen_result.result_kind !== want.result_kind)
            report_mismatch("result_kind", 32'(seen_result.result_kind),
                            32'(want.result_kind));
        if (seen_result.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", 32'(seen_result.payload_byte),
                            32'(want.payload_byte));
        if (seen_result.record_level !== want.record_level)
            report_mismatch("record_level", 32'(seen_result.record_level),
                            32'(want.record_level));
        if (seen_result.attribute_type !== want.attribute_type)
            report_mismatch("attribute_type", 32'(seen_result.attribute_type),
                            32'(want.attribute_type));
        if (seen_result.attribute_name !== want.attribute_name)
            report_mismatch("attribute_name", 32'(seen_result.attribute_name),
                            32'(want.attribute_name));
        if (seen_result.payload_length !== want.payload_length)
            report_mismatch("payload_length", seen_result.payload_length,
                            want.payload_length);
        if (seen_result.checksum_good !== want.checksum_good)
            report_mismatch("checksum_good", 32'(seen_result.checksum_good),
                            32'(want.checksum_good));
        if (seen_result.level_valid !== want.level_valid)
            report_mismatch("level_valid", 32'(seen_result.level_valid),
                            32'(want.level_valid));
        if (seen_result.halted_flag !== want.halted_flag)
            report_mismatch("halted_flag", 32'(seen_result.halted_flag),
                            32'(want.halted_flag));
    endtask

    // Byte driver: hold a stalled item, otherwise offer the next one or idle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                parse_byte(stream_byte);
                bytes_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    stream_byte <= pending_bytes.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and output stall generator.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (result_kind === KIND_SUMMARY)
                    summaries_seen++;
                else
                    payloads_seen++;
                if (halted_flag === 1'b1)
                    halts_seen++;
                check_result();
            end
            out_stall <= long_hold || ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic queue_bytes(input byte_q_t rec);
        foreach (rec[i])
            pending_bytes.push_back(rec[i]);
        bytes_queued += rec.size();
    endtask

    task automatic build_record(input logic [7:0] lvl, input logic [31:0] tn,
                                input logic [31:0] len, input bit bad,
                                output byte_q_t rec);
        logic [15:0] sum;
        logic [15:0] ck;
        logic [7:0]  b;
        rec = {};
        sum = '0;
        rec.push_back(lvl);
        for (int i = 0; i < 4; i++)
            rec.push_back(tn[i*8 +: 8]);
        for (int i = 0; i < 4; i++)
            rec.push_back(len[i*8 +: 8]);
        for (int unsigned k = 0; k < len; k++)
        begin
            b = 8'($urandom);
            sum = sum + {8'd0, b};
            rec.push_back(b);
        end
        ck = bad ? (sum ^ 16'($urandom_range(65535, 1))) : sum;
        rec.push_back(ck[7:0]);
        rec.push_back(ck[15:8]);
    endtask

    task automatic random_record(input bit allow_bad, output byte_q_t rec);
        logic [7:0]  lvl;
        logic [31:0] len;
        int          pick;
        bit          bad;
        lvl = 8'($urandom);
        if ($urandom_range(9) < 7)
            lvl = 8'($urandom_range(LEVEL_ATTACHMENT, LEVEL_MESSAGE));
        pick = int'($urandom_range(19));
        if (pick < 3)
            len = 32'd0;
        else if (pick < 17)
            len = $urandom_range(16, 1);
        else
            len = $urandom_range(60, 17);
        bad = allow_bad && ($urandom_range(3) == 0);
        build_record(lvl, $urandom, len, bad, rec);
    endtask

    task automatic fill_records(input int budget, input bit allow_bad);
        int      start;
        byte_q_t rec;
        start = bytes_queued;
        while (bytes_queued - start < budget)
        begin
            random_record(allow_bad, rec);
            queue_bytes(rec);
        end
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        // drain bytes that give no result
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_skip(input bit v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        skip_cfg = v;
        cfg_writes++;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        byte_q_t split_rec;
        byte_q_t rec;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // message level, all-ones header, zero length, zero checksum
        queue_bytes('{8'h01, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00});
        // invalid level, all-zero header, two payload bytes at the extremes
        queue_bytes('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00,
                      8'hff, 8'h00, 8'hff, 8'h00});
        wait_idle();

        // skip on: bad checksums keep the parser going
        write_skip(1'b1);
        fill_records(200, 1'b1);
        wait_idle();

        // skip off, good checksums only, with a long output hold up front
        send_idle_pct <= 72;
        recv_idle_pct <= 21;
        write_skip(1'b0);
        fill_records(200, 1'b0);
        fork
            begin
                long_hold <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold <= 1'b0;
            end
        join_none
        // stop mid-record, in the length field, with nothing outstanding
        build_record(LEVEL_ATTACHMENT, $urandom, 5, 1'b1, split_rec);
        queue_bytes(split_rec[0:6]);
        wait_idle();

        // turn skip on mid-record so the bad checksum of that record passes
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        write_skip(1'b1);
        queue_bytes(split_rec[7:$]);
        fill_records(200, 1'b1);
        build_record(LEVEL_MESSAGE, $urandom, 150, 1'b0, rec);
        queue_bytes(rec);
        wait_idle();

        // skip off, then a bad checksum halts; everything after is dropped
        write_skip(1'b0);
        fill_records(40, 1'b0);
        build_record(LEVEL_ATTACHMENT, $urandom, 6, 1'b1, rec);
        queue_bytes(rec);
        build_record(LEVEL_MESSAGE, $urandom, 4, 1'b0, rec);
        queue_bytes(rec);
        wait_idle();

        repeat (20) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never seen", 32'(expected_results.size()), 32'd0);

        $display("run covered %0d stream bytes in, %0d payload bytes and %0d summaries out",
                 bytes_accepted, payloads_seen, summaries_seen);
        $display("skip setting written %0d times, %0d halting summaries, %0d mismatches",
                 cfg_writes, halts_seen, error_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- tnef_attribute_record_parser_top.f -----
+incdir+hdl
hdl/tarp_pkg.sv
hdl/tarp_parse.sv
hdl/tnef_attribute_record_parser_top.sv
tb/sv/tnef_attribute_record_parser_top_tb.sv
